// ----- design/vsc_pkg.sv -----
// ----------------------------------------------------------------------------
// vsc_pkg
// Shared types and constants of the vacuum switch controller.
// ----------------------------------------------------------------------------
package vsc_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WINDOW = 3'd1,
    PH_CALIB  = 3'd2,
    PH_SAMPLE = 3'd3,
    PH_WAIT   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_PIN  = 2'd1,
    OP_ADC  = 2'd2,
    OP_WEND = 2'd3
  } opcode_t;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VACUUM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_VAC_REF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_HOLD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INDICATE     = 3'd4;

  localparam logic [7:0] MIN_VACUUM_RST   = 8'd20;
  localparam logic [7:0] FULL_VAC_REF_RST = 8'd211;
  localparam logic [5:0] GEN_HOLD_RST     = 6'd32;
  localparam logic [7:0] CALIB_MIN_RST    = 8'd4;
  localparam logic [7:0] INDICATE_RST     = 8'd6;
  localparam logic [7:0] BASELINE_RST     = 8'd100;
  localparam logic [7:0] TOGGLE_MAX       = 8'd255;

  typedef struct packed {
    logic [7:0] min_vacuum;
    logic [7:0] full_vacuum_ref;
    logic [5:0] gen_hold_ticks;
    logic [7:0] calib_toggle_min;
    logic [7:0] indicate_toggle_count;
  } cfg_t;

  typedef struct packed {
    logic       sense;
    logic       gen;
    logic       valve;
    phase_t     phase;
    logic [7:0] baseline;
  } result_t;

endpackage

// ----- design/vsc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// vsc_cfg_regs
// Configuration register file, written through the cfg channel.
// ----------------------------------------------------------------------------
module vsc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  output vsc_pkg::cfg_t                  cfg
);
  import vsc_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_vacuum            <= MIN_VACUUM_RST;
      cfg_r.full_vacuum_ref       <= FULL_VAC_REF_RST;
      cfg_r.gen_hold_ticks        <= GEN_HOLD_RST;
      cfg_r.calib_toggle_min      <= CALIB_MIN_RST;
      cfg_r.indicate_toggle_count <= INDICATE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_VACUUM:   cfg_r.min_vacuum            <= cfg_data;
        CFG_FULL_VAC_REF: cfg_r.full_vacuum_ref       <= cfg_data;
        CFG_GEN_HOLD:     cfg_r.gen_hold_ticks        <= cfg_data[5:0];
        CFG_CALIB_MIN:    cfg_r.calib_toggle_min      <= cfg_data;
        CFG_INDICATE:     cfg_r.indicate_toggle_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- design/vsc_base_calc.sv -----
// ----------------------------------------------------------------------------
// vsc_base_calc
// Calibrated baseline: average of the readings moved toward the reference.
// ----------------------------------------------------------------------------
module vsc_base_calc #(
  parameter int CALIB_SAMPLES = 8
) (
  input  logic [$clog2(255*CALIB_SAMPLES+1)-1:0] sum,
  input  logic [7:0]                             full_vacuum_ref,
  output logic [7:0]                             baseline
);
  localparam int SUM_W  = $clog2(255*CALIB_SAMPLES+1);
  localparam int LOG_N  = $clog2(CALIB_SAMPLES);
  localparam int SH     = SUM_W + LOG_N;
  localparam int RECIP  = ((1 << SH) + CALIB_SAMPLES - 1) / CALIB_SAMPLES;
  localparam int RCP_W  = SH + 1;
  localparam int PROD_W = SUM_W + RCP_W;

  localparam logic [RCP_W-1:0] RECIP_V = RCP_W'(RECIP);

  logic [PROD_W-1:0] prod;
  logic [7:0]        avg;
  logic [15:0]       diff;

  // divide by the sample count through a reciprocal multiply
  assign prod     = {{RCP_W{1'b0}}, sum} * {{SUM_W{1'b0}}, RECIP_V};
  assign avg      = prod[SH +: 8];
  assign diff     = {8'd0, full_vacuum_ref} - {8'd0, avg};
  assign baseline = avg + diff[10:3];

endmodule

// ----- design/vsc_core.sv -----
// ----------------------------------------------------------------------------
// vsc_core
// Controller state and per-transaction update logic.
// ----------------------------------------------------------------------------
module vsc_core #(
  parameter int CALIB_SAMPLES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  vsc_pkg::opcode_t  opcode,
  input  logic              level,
  input  logic [7:0]        adc,
  input  vsc_pkg::cfg_t     cfg,
  output vsc_pkg::result_t  res_nxt
);
  import vsc_pkg::*;

  localparam int SUM_W = $clog2(255*CALIB_SAMPLES+1);
  localparam int IDX_W = $clog2(CALIB_SAMPLES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CALIB_SAMPLES - 1);

  phase_t             phase_r, phase_nxt;
  logic               expect_r, expect_nxt;
  logic [7:0]         toggle_r, toggle_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt, sum_add;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               pair_r, pair_nxt;
  logic [7:0]         first_r, first_nxt;
  logic [7:0]         last_r, last_nxt;
  logic [7:0]         base_r, base_nxt;
  logic [5:0]         hold_r, hold_nxt, hold_inc;
  logic               sense_r, sense_nxt;
  logic               gen_r, gen_nxt;
  logic               valve_r, valve_nxt;

  logic               is_adc, pin_low, pin_high, tick_run;
  logic               pair_done, calib_done, release_hit, to_calib;
  logic [7:0]         pair_sum, calib_base;

  assign is_adc      = (opcode == OP_ADC);
  assign pin_low     = (opcode == OP_PIN) && !level;
  assign pin_high    = (opcode == OP_PIN) && level;
  assign tick_run    = (opcode == OP_TICK) && (hold_r != cfg.gen_hold_ticks);
  assign hold_inc    = hold_r + 6'd1;
  assign pair_sum    = first_r + {1'b0, adc[7:1]};
  assign pair_done   = is_adc && pair_r;
  assign sum_add     = sum_r + SUM_W'(adc);
  assign calib_done  = is_adc && (idx_r == IDX_LAST);
  assign release_hit = pair_done && (pair_sum <= cfg.min_vacuum);
  assign to_calib    = (toggle_r >= cfg.calib_toggle_min);

  vsc_base_calc #(
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) u_base_calc (
    .sum             (sum_add),
    .full_vacuum_ref (cfg.full_vacuum_ref),
    .baseline        (calib_base)
  );

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (pin_low) phase_nxt = PH_WINDOW;
      end
      PH_WINDOW: begin
        if (opcode == OP_WEND) phase_nxt = to_calib ? PH_CALIB : PH_SAMPLE;
      end
      PH_CALIB: begin
        if (calib_done) phase_nxt = PH_IDLE;
      end
      PH_SAMPLE: begin
        if (!is_adc && pin_high) phase_nxt = (last_r > base_r) ? PH_WAIT : PH_IDLE;
      end
      PH_WAIT: begin
        if (release_hit) phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // datapath update
  always_comb begin
    expect_nxt = expect_r;
    toggle_nxt = toggle_r;
    sum_nxt    = sum_r;
    idx_nxt    = idx_r;
    pair_nxt   = pair_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    base_nxt   = base_r;
    hold_nxt   = hold_r;
    sense_nxt  = sense_r;
    gen_nxt    = gen_r;
    valve_nxt  = valve_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (pin_low) begin
          expect_nxt = 1'b1;
          toggle_nxt = 8'd1;
        end else if (tick_run) begin
          hold_nxt = hold_inc;
          if (hold_inc == cfg.gen_hold_ticks) gen_nxt = 1'b0;
        end
      end
      PH_WINDOW: begin
        if (opcode == OP_PIN) begin
          if (level == expect_r) begin
            if (toggle_r != TOGGLE_MAX) toggle_nxt = toggle_r + 8'd1;
            expect_nxt = ~expect_r;
          end
        end else if (opcode == OP_WEND) begin
          if (toggle_r == cfg.indicate_toggle_count) sense_nxt = 1'b1;
          gen_nxt = 1'b1;
          if (to_calib) begin
            valve_nxt = 1'b1;
            sum_nxt   = '0;
            idx_nxt   = '0;
          end else begin
            pair_nxt = 1'b0;
            last_nxt = 8'd0;
          end
        end
      end
      PH_CALIB: begin
        if (is_adc) begin
          if (calib_done) begin
            base_nxt  = calib_base;
            sense_nxt = 1'b0;
            gen_nxt   = 1'b0;
            valve_nxt = 1'b0;
            sum_nxt   = '0;
            idx_nxt   = '0;
          end else begin
            sum_nxt = sum_add;
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      PH_SAMPLE: begin
        if (is_adc) begin
          if (pair_r) begin
            last_nxt  = pair_sum;
            pair_nxt  = 1'b0;
            sense_nxt = (pair_sum >= base_r);
          end else begin
            first_nxt = {1'b0, adc[7:1]};
            pair_nxt  = 1'b1;
          end
        end else if (pin_high) begin
          pair_nxt = 1'b0;
          if (last_r <= base_r) hold_nxt = 6'd0;
        end
      end
      PH_WAIT: begin
        if (is_adc) begin
          if (pair_r) begin
            last_nxt = pair_sum;
            pair_nxt = 1'b0;
            if (release_hit) begin
              sense_nxt = 1'b0;
              hold_nxt  = 6'd0;
            end
          end else begin
            first_nxt = {1'b0, adc[7:1]};
            pair_nxt  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      expect_r <= 1'b1;
      toggle_r <= 8'd1;
      sum_r    <= '0;
      idx_r    <= '0;
      pair_r   <= 1'b0;
      first_r  <= 8'd0;
      last_r   <= 8'd0;
      base_r   <= BASELINE_RST;
      hold_r   <= GEN_HOLD_RST;
      sense_r  <= 1'b0;
      gen_r    <= 1'b0;
      valve_r  <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      expect_r <= expect_nxt;
      toggle_r <= toggle_nxt;
      sum_r    <= sum_nxt;
      idx_r    <= idx_nxt;
      pair_r   <= pair_nxt;
      first_r  <= first_nxt;
      last_r   <= last_nxt;
      base_r   <= base_nxt;
      hold_r   <= hold_nxt;
      sense_r  <= sense_nxt;
      gen_r    <= gen_nxt;
      valve_r  <= valve_nxt;
    end
  end

  assign res_nxt.sense    = sense_nxt;
  assign res_nxt.gen      = gen_nxt;
  assign res_nxt.valve    = valve_nxt;
  assign res_nxt.phase    = phase_nxt;
  assign res_nxt.baseline = base_nxt;

endmodule

// ----- design/vacuum_switch_controller_top.sv -----
// ----------------------------------------------------------------------------
// vacuum_switch_controller_top
// Vacuum part-presence controller, one result transaction per event.
//
// Usage:
//   in_*   : event transactions (timer tick, pin sample, adc reading, window
//            end), valid/ready handshake
//   out_*  : one result transaction per event with sense, generator, valve,
//            phase and baseline after the update
//   cfg_*  : register writes, index 0..4, always ready; write only while idle
// Path: an accepted input transaction passes the input register, then the
//   result register, before out_valid rises.
// Throughput: one event per cycle while out_ready is high; the whole state
//   update is a single pass of logic between input and result registers.
// Reset: synchronous, active low; registers return to their defaults, phase
//   idle, baseline 100, generator hold timer expired, both channels empty.
// Stall: when out_ready is low the result register holds and the input
//   register keeps one more event, after which in_ready drops.
// ----------------------------------------------------------------------------
module vacuum_switch_controller_top #(
  parameter int CALIB_SAMPLES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic                          in_request_level,
  input  logic [7:0]                    in_adc_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_sense_out,
  output logic                          out_generator_on,
  output logic                          out_valve_drive,
  output logic [2:0]                    out_phase_now,
  output logic [7:0]                    out_baseline_now,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import vsc_pkg::*;

  cfg_t       cfg;
  result_t    res_nxt;
  result_t    res_r;
  logic       s1_valid_r;
  opcode_t    s1_op_r;
  logic       s1_lvl_r;
  logic [7:0] s1_adc_r;
  logic       out_valid_r;
  logic       advance, step, in_take;

  assign advance  = !out_valid_r || out_ready;
  assign step     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  vsc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vsc_core #(
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .opcode  (s1_op_r),
    .level   (s1_lvl_r),
    .adc     (s1_adc_r),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r  <= opcode_t'(in_opcode);
      s1_lvl_r <= in_request_level;
      s1_adc_r <= in_adc_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sense_out    = res_r.sense;
  assign out_generator_on = res_r.gen;
  assign out_valve_drive  = res_r.valve;
  assign out_phase_now    = res_r.phase;
  assign out_baseline_now = res_r.baseline;

endmodule
